// ----- sv/mck_pkg.sv -----
// mck_pkg: shared types, constants and the Morse code table for morse_char_keyer.
// Used by mck_front, mck_queue, mck_back and the top level; depends on nothing.
package mck_pkg;

	localparam int CHAR_W  = 8;
	localparam int TICK_W  = 16;
	localparam int DUR_W   = 18;
	localparam int LEN_W   = 3;
	localparam int BITS_W  = 5;
	localparam int IDX_W   = 6;
	localparam int NCODES  = 36;
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [TICK_W-1:0] UNIT_TICKS_RST = 16'd330;

	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_DIG_LO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_DIG_HI  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UPR_LO  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPR_HI  = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LWR_LO  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LWR_HI  = 8'h7A;
	localparam logic [IDX_W-1:0]  DIGIT_BASE = 6'd26;

	typedef enum logic [1:0] {
		K_BAD,
		K_SPACE,
		K_LETTER
	} kind_t;

	typedef enum logic [1:0] {
		U_ZERO,
		U_ONE,
		U_THREE,
		U_FOUR
	} units_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SINGLE,
		ST_MARK,
		ST_SPACE
	} state_t;

	// len symbols, bit len-1 is the first one; 1 = dah
	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [BITS_W-1:0] bits;
	} code_t;

	typedef struct packed {
		kind_t kind;
		code_t code;
	} cmd_t;

	// A..Z then 0..9
	localparam code_t CODE_TABLE [NCODES] = '{
		'{3'd2, 5'd1},  '{3'd4, 5'd8},  '{3'd4, 5'd10}, '{3'd3, 5'd4},
		'{3'd1, 5'd0},  '{3'd4, 5'd2},  '{3'd3, 5'd6},  '{3'd4, 5'd0},
		'{3'd2, 5'd0},  '{3'd4, 5'd7},  '{3'd3, 5'd5},  '{3'd4, 5'd4},
		'{3'd2, 5'd3},  '{3'd2, 5'd2},  '{3'd3, 5'd7},  '{3'd4, 5'd6},
		'{3'd4, 5'd13}, '{3'd3, 5'd2},  '{3'd3, 5'd0},  '{3'd1, 5'd1},
		'{3'd3, 5'd1},  '{3'd4, 5'd1},  '{3'd3, 5'd3},  '{3'd4, 5'd9},
		'{3'd4, 5'd11}, '{3'd4, 5'd12},
		'{3'd5, 5'd31}, '{3'd5, 5'd15}, '{3'd5, 5'd7},  '{3'd5, 5'd3},
		'{3'd5, 5'd1},  '{3'd5, 5'd0},  '{3'd5, 5'd16}, '{3'd5, 5'd24},
		'{3'd5, 5'd28}, '{3'd5, 5'd30}
	};

	function automatic logic [DUR_W-1:0] mck_duration(units_t u, logic [TICK_W-1:0] t);
		logic [DUR_W-1:0] e;
		logic [DUR_W-1:0] r;
		e = {{(DUR_W-TICK_W){1'b0}}, t};
		unique case (u)
			U_ZERO:  r = '0;
			U_ONE:   r = e;
			U_THREE: r = e + (e << 1);
			U_FOUR:  r = e << 2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- sv/mck_front.sv -----
// mck_front: accepts characters and classifies them into keying commands.
// Depends on mck_pkg; pushes into mck_queue.
module mck_front (
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [mck_pkg::CHAR_W-1:0] char_code,
	input  logic                      q_full,
	output logic                      push,
	output mck_pkg::cmd_t             push_cmd
);
	import mck_pkg::*;

	logic             is_digit;
	logic             is_alpha;
	logic [IDX_W-1:0] idx;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	assign is_digit = (char_code >= CH_DIG_LO) && (char_code <= CH_DIG_HI);
	assign is_alpha = ((char_code >= CH_UPR_LO) && (char_code <= CH_UPR_HI)) ||
	                  ((char_code >= CH_LWR_LO) && (char_code <= CH_LWR_HI));

	always_comb begin
		if (is_digit) begin
			idx = IDX_W'(char_code - CH_DIG_LO) + DIGIT_BASE;
		end else begin
			idx = {1'b0, char_code[4:0] - 5'd1};
		end
	end

	always_comb begin
		push_cmd.code = '0;
		if (char_code == CH_SPACE) begin
			push_cmd.kind = K_SPACE;
		end else if (is_digit || is_alpha) begin
			push_cmd.kind = K_LETTER;
			push_cmd.code = CODE_TABLE[idx];
		end else begin
			push_cmd.kind = K_BAD;
		end
	end

endmodule

// ----- sv/mck_queue.sv -----
// mck_queue: short command queue between the front and the back of the keyer.
// Depends on mck_pkg.
module mck_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mck_pkg::cmd_t push_cmd,
	input  logic          pop,
	output mck_pkg::cmd_t pop_cmd,
	output logic          full,
	output logic          empty
);
	import mck_pkg::*;

	cmd_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_CW-1:0] cnt_q;

	assign full    = (cnt_q == Q_CW'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == Q_AW'(Q_DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == Q_AW'(Q_DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue pop while empty");

endmodule

// ----- sv/mck_back.sv -----
// mck_back: segment sequencer; turns queued commands into timed key segments.
// Depends on mck_pkg; fed by mck_queue.
module mck_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [mck_pkg::TICK_W-1:0] unit_ticks,
	input  logic                       q_empty,
	input  mck_pkg::cmd_t              q_cmd,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       key_on,
	output logic [mck_pkg::DUR_W-1:0]  duration_ticks,
	output logic                       bad_char,
	output logic                       last
);
	import mck_pkg::*;

	state_t            state_q, state_d;
	kind_t             kind_q;
	logic [BITS_W-1:0] bits_q;
	logic [LEN_W-1:0]  sym_q;
	logic              load;

	logic              seg_key;
	units_t            seg_units;
	logic              seg_bad;
	logic              seg_last;

	logic              out_valid_q;
	logic              key_on_q;
	logic [DUR_W-1:0]  dur_q;
	logic              bad_q;
	logic              last_q;

	assign load = (state_q != ST_IDLE) && (!out_valid_q || !out_stall);
	assign pop  = (state_q == ST_IDLE) && !q_empty;

	always_comb begin
		state_d   = state_q;
		seg_key   = 1'b0;
		seg_units = U_ZERO;
		seg_bad   = 1'b0;
		seg_last  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					state_d = (q_cmd.kind == K_LETTER) ? ST_MARK : ST_SINGLE;
				end
			end
			ST_SINGLE: begin
				seg_units = (kind_q == K_BAD) ? U_ZERO : U_FOUR;
				seg_bad   = (kind_q == K_BAD);
				seg_last  = 1'b1;
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			ST_MARK: begin
				seg_key   = 1'b1;
				seg_units = bits_q[sym_q] ? U_THREE : U_ONE;
				if (load) begin
					state_d = ST_SPACE;
				end
			end
			ST_SPACE: begin
				seg_units = (sym_q == '0) ? U_THREE : U_ONE;
				seg_last  = (sym_q == '0);
				if (load) begin
					state_d = (sym_q == '0) ? ST_IDLE : ST_MARK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= q_cmd.kind;
			bits_q <= q_cmd.code.bits;
			sym_q  <= q_cmd.code.len - 1'b1;
		end else if (load && (state_q == ST_SPACE) && (sym_q != '0)) begin
			sym_q <= sym_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_on_q <= seg_key;
			dur_q    <= mck_duration(seg_units, unit_ticks);
			bad_q    <= seg_bad;
			last_q   <= seg_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign key_on         = key_on_q;
	assign duration_ticks = dur_q;
	assign bad_char       = bad_q;
	assign last           = last_q;

	a_sym_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MARK || state_q == ST_SPACE) |-> (sym_q <= 3'd4))
		else $error("symbol index out of range");

	a_mark_then_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(load && state_q == ST_MARK) |=> (state_q == ST_SPACE && key_on_q && !last_q))
		else $error("key-down segment not followed by gap");

	a_letter_end: assert property (@(posedge clk) disable iff (!arst_n)
		(load && state_q == ST_SPACE && sym_q == '0) |=> (state_q == ST_IDLE && last_q))
		else $error("letter did not end with last segment");

	a_single_end: assert property (@(posedge clk) disable iff (!arst_n)
		(load && state_q == ST_SINGLE) |=> (state_q == ST_IDLE && last_q && !key_on_q))
		else $error("single segment item not closed");

endmodule

// ----- sv/morse_char_keyer.sv -----
// morse_char_keyer: top level; ties the front, the command queue and the sequencer.
// Depends on mck_pkg, mck_front, mck_queue and mck_back.
//
// Takes one ASCII character per item and gives a run of key segments (level and
// length in ticks). A letter or digit of n symbols gives 2n segments, one per
// cycle while out_stall does not hold them back, after the sequencer has fetched
// the command from the queue; a space or an unknown character gives one segment,
// the latter flagged bad_char with zero length. The sequencer emitting one segment
// per cycle, when the output is not stalled, sets the rate; a two-entry command
// queue lets new characters be taken while earlier ones are still being keyed.
// unit_ticks resets to 330 and should be written only while the keyer is idle.
module morse_char_keyer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [mck_pkg::TICK_W-1:0] unit_ticks,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [mck_pkg::CHAR_W-1:0] char_code,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       key_on,
	output logic [mck_pkg::DUR_W-1:0]  duration_ticks,
	output logic                       bad_char,
	output logic                       last
);
	import mck_pkg::*;

	logic [TICK_W-1:0] unit_ticks_q;
	logic              push;
	cmd_t              push_cmd;
	logic              pop;
	cmd_t              pop_cmd;
	logic              q_full;
	logic              q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q <= UNIT_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unit_ticks_q <= unit_ticks;
		end
	end

	mck_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	mck_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	mck_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.unit_ticks     (unit_ticks_q),
		.q_empty        (q_empty),
		.q_cmd          (pop_cmd),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.key_on         (key_on),
		.duration_ticks (duration_ticks),
		.bad_char       (bad_char),
		.last           (last)
	);

endmodule

// ----- tb/tb_morse_char_keyer.sv -----
// tb_morse_char_keyer: self-checking testbench for the Morse character keyer.
// Predicts each key segment from its own Morse table and checks the block's output stream.
// Depends on mck_pkg (widths) and morse_char_keyer.
module tb_morse_char_keyer;
	import mck_pkg::*;

	localparam int           CYCLE_LIMIT = 400000;
	localparam int           HOLD_CYCLES = 300;
	localparam int           TAIL_CYCLES = 40;

	typedef struct packed {
		logic             key;
		logic [DUR_W-1:0] dur;
		logic             bad;
		logic             fin;
	} segment_t;

	// A..Z then 0..9
	string morse_tab [36] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
		"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
		"..-", "...-", ".--", "-..-", "-.--", "--..",
		"-----", ".----", "..---", "...--", "....-",
		".....", "-....", "--...", "---..", "----."
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [TICK_W-1:0]  unit_ticks = 16'd330;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [CHAR_W-1:0]  char_code = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               key_on;
	logic [DUR_W-1:0]   duration_ticks;
	logic               bad_char;
	logic               last;

	logic [CHAR_W-1:0]  char_pending [$];
	segment_t           seg_expected [$];
	logic [TICK_W-1:0]  unit_now = 16'd330;
	int unsigned        chars_queued = 0;
	int unsigned        chars_accepted = 0;
	int unsigned        seg_count = 0;
	int unsigned        mismatch_count = 0;
	int unsigned        cycle_count = 0;
	int unsigned        snd_idle_pct = 0;
	int unsigned        rcv_idle_pct = 0;
	int unsigned        hold_reqs = 0;
	int unsigned        hold_served = 0;
	int unsigned        hold_left = 0;
	logic               char_taken = 1'b0;
	logic [TICK_W-1:0]  mid_unit;

	morse_char_keyer uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.unit_ticks     (unit_ticks),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.char_code      (char_code),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.key_on         (key_on),
		.duration_ticks (duration_ticks),
		.bad_char       (bad_char),
		.last           (last)
	);

	always #4 clk = ~clk;

	function automatic logic [DUR_W-1:0] seg_length(int unsigned units);
		logic [31:0] p;
		p = units * unit_now;
		return p[DUR_W-1:0];
	endfunction

	function automatic void push_segment(logic k, int unsigned units, logic b, logic f);
		segment_t s;
		s.key = k;
		s.dur = seg_length(units);
		s.bad = b;
		s.fin = f;
		seg_expected.push_back(s);
	endfunction

	function automatic void expand_char(logic [CHAR_W-1:0] c);
		int    idx;
		string code;
		idx = -1;
		if (c == 8'h20) begin
			push_segment(1'b0, 4, 1'b0, 1'b1);
			return;
		end
		if (c >= 8'h30 && c <= 8'h39)
			idx = c - 8'h30 + 26;
		else if (c >= 8'h41 && c <= 8'h5A)
			idx = c - 8'h41;
		else if (c >= 8'h61 && c <= 8'h7A)
			idx = c - 8'h61;
		if (idx < 0) begin
			push_segment(1'b0, 0, 1'b1, 1'b1);
			return;
		end
		code = morse_tab[idx];
		for (int i = 0; i < code.len(); i++) begin
			push_segment(1'b1, (code[i] == "-") ? 3 : 1, 1'b0, 1'b0);
			if (i == code.len() - 1)
				push_segment(1'b0, 3, 1'b0, 1'b1);
			else
				push_segment(1'b0, 1, 1'b0, 1'b0);
		end
	endfunction

	function automatic logic [CHAR_W-1:0] pick_char();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 35)
			return CHAR_W'(8'h41 + $urandom_range(25));
		else if (r < 60)
			return CHAR_W'(8'h61 + $urandom_range(25));
		else if (r < 72)
			return CHAR_W'(8'h30 + $urandom_range(9));
		else if (r < 82)
			return 8'h20;
		return CHAR_W'($urandom_range(255));
	endfunction

	task automatic report_mismatch(input string field, input int unsigned got,
			input int unsigned want);
		$display("mismatch in %s at segment %0d: got %0d, expected %0d",
			field, seg_count, got, want);
		mismatch_count++;
	endtask

	task automatic set_idle(input int unsigned snd, input int unsigned rcv);
		@(posedge clk);
		snd_idle_pct = snd;
		rcv_idle_pct = rcv;
	endtask

	task automatic queue_chars(input logic [CHAR_W-1:0] chars [$]);
		@(posedge clk);
		foreach (chars[i]) begin
			char_pending.push_back(chars[i]);
			chars_queued++;
		end
	endtask

	task automatic queue_random(input int n);
		logic [CHAR_W-1:0] chars [$];
		for (int i = 0; i < n; i++)
			chars.push_back(pick_char());
		queue_chars(chars);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (chars_accepted != chars_queued || seg_expected.size() != 0);
	endtask

	task automatic write_unit(input logic [TICK_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		unit_ticks <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		unit_now = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// sender
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || char_taken) begin
			if (char_pending.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				in_valid <= 1'b1;
				char_code <= char_pending.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
		char_taken = 1'b0;
	end

	// receiver stall, with the long hold-off
	always @(negedge clk) begin
		if (hold_served != hold_reqs) begin
			hold_served <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// accepted items in, segments out
	always @(posedge clk) begin
		segment_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expand_char(char_code);
				chars_accepted++;
				char_taken = 1'b1;
			end
			if (out_valid && !out_stall) begin
				if (seg_expected.size() == 0) begin
					report_mismatch("segment with none expected", 1, 0);
				end else begin
					want = seg_expected.pop_front();
					if (key_on !== want.key)
						report_mismatch("key_on", key_on, want.key);
					if (duration_ticks !== want.dur)
						report_mismatch("duration_ticks", duration_ticks, want.dur);
					if (bad_char !== want.bad)
						report_mismatch("bad_char", bad_char, want.bad);
					if (last !== want.fin)
						report_mismatch("last", last, want.fin);
				end
				seg_count++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// reset unit length, extremes and odd characters
		set_idle(6, 87);
		queue_chars('{8'h41, 8'h5A, 8'h61, 8'h7A, 8'h30, 8'h39, 8'h45, 8'h54,
			8'h20, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2F, 8'h3A, 8'h00, 8'hFF,
			8'h80, 8'h7F, 8'h51, 8'h35, 8'h68});
		wait_drained();

		write_unit(16'hFFFF);
		queue_random(100);
		wait_drained();

		write_unit(16'd1);
		set_idle(87, 6);
		queue_random(100);
		wait_drained();

		mid_unit = TICK_W'($urandom_range(2, 65534));
		write_unit(mid_unit);
		set_idle(0, 0);
		queue_random(100);
		hold_reqs++;
		wait_drained();

		// zero unit length: sequence unchanged, all lengths zero
		write_unit(16'd0);
		queue_random(15);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d characters keyed into %0d segments", chars_accepted, seg_count);
		$display("unit lengths 330, 65535, 1, %0d and 0; one long output hold-off",
			mid_unit);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
